@@ design/mpt_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Mosaic pixelate transition package
// Shared types, register indexes and command codes of the mosaic core.
// -----------------------------------------------------------------------------
package mpt_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int ADDR_W     = 12;
    localparam int DIV_STEPS  = 7;

    // Input request modes
    localparam logic [1:0] MODE_WRITE_A = 2'd0;
    localparam logic [1:0] MODE_WRITE_B = 2'd1;
    localparam logic [1:0] MODE_READ    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REGION_WIDTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_HEIGHT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSITION_ENABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PROGRESS_Q10      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_BLOCK        = 3'd5;

    // Q10 progress landmarks
    localparam logic [10:0] HALF_Q10 = 11'd512;
    localparam logic [10:0] ONE_Q10  = 11'd1024;

    typedef struct packed {
        logic [7:0]  region_width;
        logic [6:0]  region_height;
        logic [7:0]  block_size;
        logic        transition_enable;
        logic [10:0] progress_q10;
        logic [7:0]  peak_block;
    } cfg_t;

    typedef enum logic [1:0] {
        CMD_WRITE_A,
        CMD_WRITE_B,
        CMD_READ
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
        logic [6:0]        column;
        logic [5:0]        row;
        logic [7:0]        blk;
        logic              sel_b;
        logic              valid;
    } cmd_t;

    typedef enum logic [1:0] {
        F_ACCEPT,
        F_MUL,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DIV,
        B_SAMPLE,
        B_ADDR,
        B_READ,
        B_RESULT
    } back_state_t;

endpackage

@@ design/mpt_queue.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Mosaic command queue
// Two-entry FIFO of decoded commands between the front and back ends.
// -----------------------------------------------------------------------------
module mpt_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  mpt_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop,
    output mpt_pkg::cmd_t pop_cmd
);

    localparam logic [1:0] DEPTH = 2'd2;

    mpt_pkg::cmd_t entry_reg [2];
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != DEPTH);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ design/mpt_front.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Mosaic front end
// Accepts requests, computes write addresses, block size and read validity,
// and hands decoded commands to the queue.
// -----------------------------------------------------------------------------
module mpt_front #(
    parameter int CANVAS_WIDTH  = 128,
    parameter int CANVAS_HEIGHT = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  mpt_pkg::cfg_t cfg,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [31:0]   s_tdata,
    output logic          push_valid,
    input  logic          push_ready,
    output mpt_pkg::cmd_t push_cmd
);

    localparam int         PAGES       = (CANVAS_HEIGHT + 7) / 8;
    localparam int         STORE_DEPTH = CANVAS_WIDTH * PAGES;
    localparam logic [12:0] DEPTH_V    = 13'(STORE_DEPTH);
    localparam logic [8:0]  CW_V       = 9'(CANVAS_WIDTH);
    localparam logic [7:0]  CH_V       = 8'(CANVAS_HEIGHT);

    mpt_pkg::front_state_t state_reg;
    mpt_pkg::front_state_t state_next;

    logic [1:0]  mode_reg;
    logic [6:0]  column_reg;
    logic [2:0]  page_reg;
    logic [5:0]  row_reg;
    logic [7:0]  byte_reg;
    logic [17:0] prod_reg;
    logic [17:0] prod_next;
    logic        lower_reg;
    logic        lower_next;

    logic        accept;
    logic        load_prod;
    logic [7:0]  m_eff;
    logic [7:0]  m_minus1;
    logic [10:0] p_sat;
    logic [9:0]  mul_in;
    logic [18:0] grow_sum;
    logic [18:0] shrink_sum;
    logic [10:0] raw_blk;
    logic [7:0]  trans_blk;
    logic [7:0]  blk;
    logic        valid;
    logic [12:0] waddr;
    logic        is_write;
    logic        waddr_ok;

    assign accept = s_tvalid && s_tready;

    // Transition block size: the product is registered, the rounding follows.
    always_comb
    begin
        m_eff      = (cfg.peak_block == 8'd0) ? 8'd1 : cfg.peak_block;
        m_minus1   = m_eff - 8'd1;
        p_sat      = (cfg.progress_q10 > mpt_pkg::ONE_Q10) ? mpt_pkg::ONE_Q10
                                                           : cfg.progress_q10;
        lower_next = (p_sat < mpt_pkg::HALF_Q10);
        mul_in     = lower_next ? p_sat[9:0] : 10'(p_sat - mpt_pkg::HALF_Q10);
        prod_next  = {10'b0, m_minus1} * {8'b0, mul_in};

        grow_sum   = {1'b0, prod_reg} + 19'd256;
        shrink_sum = {2'b0, m_eff, 9'b0} - {1'b0, prod_reg} + 19'd256;
        raw_blk    = lower_reg ? ({1'b0, grow_sum[18:9]} + 11'd1)
                               : {1'b0, shrink_sum[18:9]};
        if (raw_blk == 11'd0)
        begin
            trans_blk = 8'd1;
        end
        else if (raw_blk > {3'b0, m_eff})
        begin
            trans_blk = m_eff;
        end
        else
        begin
            trans_blk = raw_blk[7:0];
        end
    end

    always_comb
    begin
        blk   = cfg.transition_enable ? trans_blk : cfg.block_size;
        valid = (cfg.region_width != 8'd0) && (cfg.region_height != 7'd0) &&
                ({1'b0, cfg.region_width} <= CW_V) &&
                ({1'b0, cfg.region_height} <= CH_V);
        if (cfg.transition_enable)
        begin
            if (({1'b0, cfg.region_width} != CW_V) ||
                ({1'b0, cfg.region_height} != CH_V))
            begin
                valid = 1'b0;
            end
        end
        else if (cfg.block_size == 8'd0)
        begin
            valid = 1'b0;
        end
        if (({1'b0, column_reg} >= cfg.region_width) ||
            ({1'b0, row_reg} >= cfg.region_height))
        begin
            valid = 1'b0;
        end

        waddr    = ({10'b0, page_reg} * {5'b0, cfg.region_width}) + {6'b0, column_reg};
        waddr_ok = (waddr < DEPTH_V);
        is_write = (mode_reg == mpt_pkg::MODE_WRITE_A) ||
                   (mode_reg == mpt_pkg::MODE_WRITE_B);
    end

    always_comb
    begin
        push_cmd.kind   = (mode_reg == mpt_pkg::MODE_WRITE_A) ? mpt_pkg::CMD_WRITE_A :
                          (mode_reg == mpt_pkg::MODE_WRITE_B) ? mpt_pkg::CMD_WRITE_B :
                                                                mpt_pkg::CMD_READ;
        push_cmd.addr   = waddr[mpt_pkg::ADDR_W-1:0];
        push_cmd.data   = byte_reg;
        push_cmd.column = column_reg;
        push_cmd.row    = row_reg;
        push_cmd.blk    = blk;
        push_cmd.sel_b  = cfg.transition_enable && (cfg.progress_q10 >= mpt_pkg::HALF_Q10);
        push_cmd.valid  = valid;
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        push_valid = 1'b0;
        load_prod  = 1'b0;
        case (state_reg)
            mpt_pkg::F_ACCEPT:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    case (s_tdata[1:0])
                        mpt_pkg::MODE_WRITE_A, mpt_pkg::MODE_WRITE_B:
                            state_next = mpt_pkg::F_PUSH;
                        mpt_pkg::MODE_READ:
                            state_next = mpt_pkg::F_MUL;
                        default:
                            state_next = mpt_pkg::F_ACCEPT;
                    endcase
                end
            end
            mpt_pkg::F_MUL:
            begin
                load_prod  = 1'b1;
                state_next = mpt_pkg::F_PUSH;
            end
            mpt_pkg::F_PUSH:
            begin
                // A byte write that falls outside the store is dropped here.
                if (is_write && !waddr_ok)
                begin
                    state_next = mpt_pkg::F_ACCEPT;
                end
                else
                begin
                    push_valid = 1'b1;
                    if (push_ready)
                    begin
                        state_next = mpt_pkg::F_ACCEPT;
                    end
                end
            end
            default:
            begin
                state_next = mpt_pkg::F_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mpt_pkg::F_ACCEPT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= s_tdata[1:0];
            column_reg <= s_tdata[8:2];
            page_reg   <= s_tdata[11:9];
            row_reg    <= s_tdata[17:12];
            byte_reg   <= s_tdata[25:18];
        end
        if (load_prod)
        begin
            prod_reg  <= prod_next;
            lower_reg <= lower_next;
        end
    end

endmodule

@@ design/mpt_back.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Mosaic back end
// Holds both source stores, executes byte writes and computes mosaic pixels
// with an iterative divider, sample and address stages and a store read.
// -----------------------------------------------------------------------------
module mpt_back #(
    parameter int CANVAS_WIDTH  = 128,
    parameter int CANVAS_HEIGHT = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    region_width,
    input  logic [6:0]    region_height,
    input  logic          pop_valid,
    output logic          pop,
    input  mpt_pkg::cmd_t pop_cmd,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata
);

    localparam int          PAGES       = (CANVAS_HEIGHT + 7) / 8;
    localparam int          STORE_DEPTH = CANVAS_WIDTH * PAGES;
    localparam int          AW          = $clog2(STORE_DEPTH);
    localparam logic [12:0] DEPTH_V     = 13'(STORE_DEPTH);
    localparam logic [2:0]  LAST_STEP   = 3'(mpt_pkg::DIV_STEPS - 1);

    logic [7:0] store_a [STORE_DEPTH];
    logic [7:0] store_b [STORE_DEPTH];

    mpt_pkg::back_state_t state_reg;
    mpt_pkg::back_state_t state_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_on_reg;
    logic        out_pv_reg;
    logic        blk_load;
    logic        div_step;
    logic        sample_load;
    logic        addr_load;
    logic        read_en;
    logic        out_load;
    logic        wr_a_en;
    logic        wr_b_en;

    logic [7:0]  blk_reg;
    logic        sel_b_reg;
    logic        valid_reg;
    logic [2:0]  cnt_reg;
    logic [6:0]  dvd_x_reg;
    logic [6:0]  dvd_y_reg;
    logic [7:0]  rem_x_reg;
    logic [7:0]  rem_y_reg;
    logic [6:0]  q_x_reg;
    logic [6:0]  q_y_reg;
    logic [7:0]  sx_reg;
    logic [6:0]  sy_reg;
    logic [11:0] raddr_reg;
    logic        rin_reg;
    logic [7:0]  rd_a_reg;
    logic [7:0]  rd_b_reg;

    logic [8:0]  trial_x;
    logic [8:0]  trial_y;
    logic        ge_x;
    logic        ge_y;
    logic [7:0]  rem_x_next;
    logic [7:0]  rem_y_next;
    logic [15:0] sx_full;
    logic [15:0] sy_full;
    logic [7:0]  rw_m1;
    logic [6:0]  rh_m1;
    logic [7:0]  sx_next;
    logic [6:0]  sy_next;
    logic [11:0] raddr_next;
    logic [7:0]  rd_sel;
    logic        pixel_bit;

    // One restoring division step for column and row in parallel.
    always_comb
    begin
        trial_x    = {rem_x_reg, dvd_x_reg[6]};
        trial_y    = {rem_y_reg, dvd_y_reg[6]};
        ge_x       = (trial_x >= {1'b0, blk_reg});
        ge_y       = (trial_y >= {1'b0, blk_reg});
        rem_x_next = ge_x ? 8'(trial_x - {1'b0, blk_reg}) : trial_x[7:0];
        rem_y_next = ge_y ? 8'(trial_y - {1'b0, blk_reg}) : trial_y[7:0];
    end

    // Sample point is the block origin plus half a block, clamped to the region.
    always_comb
    begin
        rw_m1   = region_width - 8'd1;
        rh_m1   = region_height - 7'd1;
        sx_full = ({9'b0, q_x_reg} * {8'b0, blk_reg}) + {9'b0, blk_reg[7:1]};
        sy_full = ({9'b0, q_y_reg} * {8'b0, blk_reg}) + {9'b0, blk_reg[7:1]};
        sx_next = (sx_full > {8'b0, rw_m1}) ? rw_m1 : sx_full[7:0];
        sy_next = (sy_full > {9'b0, rh_m1}) ? rh_m1 : sy_full[6:0];
        raddr_next = ({8'b0, sy_reg[6:3]} * {4'b0, region_width}) + {4'b0, sx_reg};
        rd_sel     = sel_b_reg ? rd_b_reg : rd_a_reg;
        pixel_bit  = rd_sel[sy_reg[2:0]];
    end

    always_comb
    begin
        state_next  = state_reg;
        pop         = 1'b0;
        blk_load    = 1'b0;
        div_step    = 1'b0;
        sample_load = 1'b0;
        addr_load   = 1'b0;
        read_en     = 1'b0;
        out_load    = 1'b0;
        wr_a_en     = 1'b0;
        wr_b_en     = 1'b0;
        case (state_reg)
            mpt_pkg::B_IDLE:
            begin
                pop = pop_valid;
                if (pop_valid)
                begin
                    case (pop_cmd.kind)
                        mpt_pkg::CMD_WRITE_A: wr_a_en = 1'b1;
                        mpt_pkg::CMD_WRITE_B: wr_b_en = 1'b1;
                        mpt_pkg::CMD_READ:
                        begin
                            blk_load   = 1'b1;
                            state_next = pop_cmd.valid ? mpt_pkg::B_DIV : mpt_pkg::B_RESULT;
                        end
                        default:
                        begin
                            state_next = mpt_pkg::B_IDLE;
                        end
                    endcase
                end
            end
            mpt_pkg::B_DIV:
            begin
                div_step = 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = mpt_pkg::B_SAMPLE;
                end
            end
            mpt_pkg::B_SAMPLE:
            begin
                sample_load = 1'b1;
                state_next  = mpt_pkg::B_ADDR;
            end
            mpt_pkg::B_ADDR:
            begin
                addr_load  = 1'b1;
                state_next = mpt_pkg::B_READ;
            end
            mpt_pkg::B_READ:
            begin
                read_en    = 1'b1;
                state_next = mpt_pkg::B_RESULT;
            end
            mpt_pkg::B_RESULT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = mpt_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = mpt_pkg::B_IDLE;
            end
        endcase
        out_valid_next = (out_valid_reg && !m_tready) || out_load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mpt_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (blk_load)
        begin
            blk_reg   <= pop_cmd.blk;
            sel_b_reg <= pop_cmd.sel_b;
            valid_reg <= pop_cmd.valid;
            dvd_x_reg <= pop_cmd.column;
            dvd_y_reg <= {1'b0, pop_cmd.row};
            rem_x_reg <= 8'd0;
            rem_y_reg <= 8'd0;
            q_x_reg   <= 7'd0;
            q_y_reg   <= 7'd0;
            cnt_reg   <= 3'd0;
            rin_reg   <= 1'b0;
        end
        if (div_step)
        begin
            dvd_x_reg <= {dvd_x_reg[5:0], 1'b0};
            dvd_y_reg <= {dvd_y_reg[5:0], 1'b0};
            rem_x_reg <= rem_x_next;
            rem_y_reg <= rem_y_next;
            q_x_reg   <= {q_x_reg[5:0], ge_x};
            q_y_reg   <= {q_y_reg[5:0], ge_y};
            cnt_reg   <= cnt_reg + 3'd1;
        end
        if (sample_load)
        begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
        end
        if (addr_load)
        begin
            raddr_reg <= raddr_next;
            rin_reg   <= ({1'b0, raddr_next} < DEPTH_V);
        end
        if (out_load)
        begin
            out_pv_reg <= valid_reg;
            out_on_reg <= valid_reg && rin_reg && pixel_bit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_a_en)
        begin
            store_a[pop_cmd.addr[AW-1:0]] <= pop_cmd.data;
        end
        if (wr_b_en)
        begin
            store_b[pop_cmd.addr[AW-1:0]] <= pop_cmd.data;
        end
        if (read_en)
        begin
            rd_a_reg <= store_a[raddr_reg[AW-1:0]];
            rd_b_reg <= store_b[raddr_reg[AW-1:0]];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_pv_reg, out_on_reg};

endmodule

@@ design/mosaic_pixelate_transition_core.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Mosaic pixelate transition core
// Two page-packed monochrome source stores and a mosaic pixel reader with a
// direct mode and a progress-driven A-to-B transition mode.
// -----------------------------------------------------------------------------
// A request is either a byte write into store A or B or a pixel read. The
// front end takes a write through its accept and push states and a read
// through accept, multiply and push, and takes no new request before the
// last is pushed; a queue of two commands lets it run ahead of the back end.
// The back end writes a byte as it pops it. A valid read goes through the
// pop, seven iterations of the shift-subtract divider that finds the block
// index of column and row, the sample and address multiplies, the store read
// and the result register; one invalid by setting or coordinate goes
// straight to the result register. No command is popped during a read,
// nor while a result waits for m_tready. Configuration must stay still
// while requests are in flight. Store contents are not cleared by reset.
// -----------------------------------------------------------------------------
module mosaic_pixelate_transition_core #(
    parameter int CANVAS_WIDTH  = 128,
    parameter int CANVAS_HEIGHT = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mpt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mpt_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // mode[1:0], column[8:2], page[11:9], row[17:12], byte_value[25:18], zero
    input  logic [31:0]                     s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pixel_on[0], pixel_valid[1], zero
    output logic [7:0]                      m_tdata
);

    mpt_pkg::cfg_t cfg_reg;
    mpt_pkg::cmd_t push_cmd;
    mpt_pkg::cmd_t pop_cmd;
    logic          push_valid;
    logic          push_ready;
    logic          pop_valid;
    logic          pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.region_width      <= 8'd128;
            cfg_reg.region_height     <= 7'd64;
            cfg_reg.block_size        <= 8'd1;
            cfg_reg.transition_enable <= 1'b0;
            cfg_reg.progress_q10      <= 11'd0;
            cfg_reg.peak_block        <= 8'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mpt_pkg::REG_REGION_WIDTH:      cfg_reg.region_width      <= cfg_data[7:0];
                mpt_pkg::REG_REGION_HEIGHT:     cfg_reg.region_height     <= cfg_data[6:0];
                mpt_pkg::REG_BLOCK_SIZE:        cfg_reg.block_size        <= cfg_data[7:0];
                mpt_pkg::REG_TRANSITION_ENABLE: cfg_reg.transition_enable <= cfg_data[0];
                mpt_pkg::REG_PROGRESS_Q10:      cfg_reg.progress_q10      <= cfg_data;
                mpt_pkg::REG_PEAK_BLOCK:        cfg_reg.peak_block        <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    mpt_front #(
        .CANVAS_WIDTH  (CANVAS_WIDTH),
        .CANVAS_HEIGHT (CANVAS_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    mpt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_cmd    (pop_cmd)
    );

    mpt_back #(
        .CANVAS_WIDTH  (CANVAS_WIDTH),
        .CANVAS_HEIGHT (CANVAS_HEIGHT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .region_width  (cfg_reg.region_width),
        .region_height (cfg_reg.region_height),
        .pop_valid     (pop_valid),
        .pop           (pop),
        .pop_cmd       (pop_cmd),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

endmodule
